@@ rtl/core/aob_pkg.sv @@
`default_nettype none

package aob_pkg;

   // Configuration register indexes.
   localparam logic [2:0] RegSrcChannels = 3'd0;
   localparam logic [2:0] RegDstChannels = 3'd1;
   localparam logic [2:0] RegOffsetX     = 3'd2;
   localparam logic [2:0] RegOffsetY     = 3'd3;
   localparam logic [2:0] RegDstWidth    = 3'd4;
   localparam logic [2:0] RegDstHeight   = 3'd5;

   // Alpha thresholds: opaque byte level and the combined alpha floor (0.01 * 65025).
   localparam logic [7:0]  OpaqueLevel = 8'd253;
   localparam logic [15:0] AlphaFloor  = 16'd650;
   localparam logic [7:0]  FullAlpha   = 8'd255;
   localparam logic [2:0]  MaxChannels = 3'd4;

   // Number of quotient bits resolved in each division stage.
   localparam int unsigned DivBitsPerStage = 2;

   // Per-item sideband that rides along the whole pipeline.
   typedef struct packed {
      logic             in_bounds;
      logic [11:0]      dst_x;
      logic [11:0]      dst_y;
      logic             copy;
      logic             blend;
      logic [3:0]       mask;
      logic [3:0][7:0]  cpy;
      logic [7:0]       alpha;
   } side_type;

   // After channel substitution and alpha selection.
   typedef struct packed {
      side_type         side;
      logic [7:0]       sa;
      logic [7:0]       da;
      logic [2:0][7:0]  s;
      logic [2:0][7:0]  d;
   } prep_type;

   // After the first products.
   typedef struct packed {
      side_type         side;
      logic [7:0]       inv;
      logic [15:0]      comb_a;
      logic [2:0][15:0] p;
      logic [2:0][15:0] q;
   } prod_type;

   // Division in progress: partial remainders and quotients per color lane.
   typedef struct packed {
      side_type         side;
      logic [15:0]      comb_a;
      logic [2:0][23:0] rem;
      logic [2:0][7:0]  quo;
   } div_type;

   // Result item as presented on the output channel.
   typedef struct packed {
      logic             write_enable;
      logic [11:0]      dst_x;
      logic [11:0]      dst_y;
      logic [3:0][7:0]  chan;
   } out_type;

   // Channel counts of 0 act as 1, above 4 act as 4.
   function automatic logic [2:0] chan_count(input logic [2:0] v);
      logic [2:0] r;
      r = v;
      if (v == 3'd0) begin
         r = 3'd1;
      end else if (v > MaxChannels) begin
         r = MaxChannels;
      end
      return r;
   endfunction

   // Two restoring division steps for quotient bits hi and hi-1 on every lane.
   function automatic div_type div_steps(input div_type x, input int unsigned hi);
      div_type     y;
      logic [23:0] t;
      int unsigned b;
      y = x;
      for (int unsigned j = 0; j < DivBitsPerStage; j++) begin
         b = hi - j;
         t = 24'({8'd0, x.comb_a} << b);
         for (int unsigned k = 0; k < 3; k++) begin
            if (y.rem[k] >= t) begin
               y.rem[k] = y.rem[k] - t;
               y.quo[k][b[2:0]] = 1'b1;
            end
         end
      end
      return y;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/alpha_over_blend.sv @@
// Throughput: one pixel per cycle while rsp_ready holds; the 8-bit restoring divide is
// spread two quotient bits per stage over four stages, each stage stalling only when full.
// Reset (synchronous, active high) empties the pipeline and restores the
// configuration to 4 channels, zero offsets and a 4096 x 4096 destination.
`default_nettype none

module alpha_over_blend #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [11:0] req_src_x,
   input  wire logic [11:0] req_src_y,
   input  wire logic [7:0]  req_src_c0,
   input  wire logic [7:0]  req_src_c1,
   input  wire logic [7:0]  req_src_c2,
   input  wire logic [7:0]  req_src_c3,
   input  wire logic [7:0]  req_dst_c0,
   input  wire logic [7:0]  req_dst_c1,
   input  wire logic [7:0]  req_dst_c2,
   input  wire logic [7:0]  req_dst_c3,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_write_enable,
   output logic [11:0]      rsp_dst_x,
   output logic [11:0]      rsp_dst_y,
   output logic [7:0]       rsp_out_c0,
   output logic [7:0]       rsp_out_c1,
   output logic [7:0]       rsp_out_c2,
   output logic [7:0]       rsp_out_c3
);

   localparam int unsigned Stages   = 7;
   localparam int unsigned DivLevels = 3;
   localparam logic [17:0] MaxDim   = 18'(MAX_DIM);

   // Configuration registers.
   logic [2:0]  src_channels_ff;
   logic [2:0]  dst_channels_ff;
   logic [15:0] offset_x_ff;
   logic [15:0] offset_y_ff;
   logic [12:0] dst_width_ff;
   logic [12:0] dst_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_channels_ff <= 3'd4;
         dst_channels_ff <= 3'd4;
         offset_x_ff     <= 16'd0;
         offset_y_ff     <= 16'd0;
         dst_width_ff    <= 13'd4096;
         dst_height_ff   <= 13'd4096;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            aob_pkg::RegSrcChannels: src_channels_ff <= csr_data[2:0];
            aob_pkg::RegDstChannels: dst_channels_ff <= csr_data[2:0];
            aob_pkg::RegOffsetX:     offset_x_ff     <= csr_data;
            aob_pkg::RegOffsetY:     offset_y_ff     <= csr_data;
            aob_pkg::RegDstWidth:    dst_width_ff    <= csr_data[12:0];
            aob_pkg::RegDstHeight:   dst_height_ff   <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Stage registers and their valid bits.
   logic [Stages-1:0]          valid_ff;
   logic [Stages-1:0]          valid_in;
   logic [Stages-1:0]          en;
   aob_pkg::prep_type          prep_ff, prep_in;
   aob_pkg::prod_type          prod_ff, prod_in;
   aob_pkg::div_type           div_ff [DivLevels+1];
   aob_pkg::div_type           div_in [DivLevels+1];
   aob_pkg::out_type           out_ff, out_in;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      en[Stages-1] = !valid_ff[Stages-1] || rsp_ready;
      for (int i = Stages - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = req_valid;
      for (int i = 1; i < Stages; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[Stages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < Stages; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Stage 1: target mapping, bounds check, channel substitution, alpha selection and copy values.
   always_comb begin
      logic [2:0]       sc;
      logic [2:0]       dc;
      logic [17:0]      tx;
      logic [17:0]      ty;
      logic [17:0]      w_eff;
      logic [17:0]      h_eff;
      logic [3:0][7:0]  s;
      logic [7:0]       sa;
      logic [7:0]       da;
      sc = aob_pkg::chan_count(src_channels_ff);
      dc = aob_pkg::chan_count(dst_channels_ff);
      tx = {6'd0, req_src_x} + {{2{offset_x_ff[15]}}, offset_x_ff};
      ty = {6'd0, req_src_y} + {{2{offset_y_ff[15]}}, offset_y_ff};
      w_eff = ({5'd0, dst_width_ff} > MaxDim) ? MaxDim : {5'd0, dst_width_ff};
      h_eff = ({5'd0, dst_height_ff} > MaxDim) ? MaxDim : {5'd0, dst_height_ff};

      s[0] = req_src_c0;
      s[1] = (sc > 3'd1) ? req_src_c1 : req_src_c0;
      s[2] = (sc > 3'd2) ? req_src_c2 : req_src_c0;
      s[3] = (sc > 3'd3) ? req_src_c3 : req_src_c0;
      sa = (sc < aob_pkg::MaxChannels) ? aob_pkg::FullAlpha : s[3];
      da = (dc < aob_pkg::MaxChannels) ? aob_pkg::FullAlpha : req_dst_c3;

      prep_in = '0;
      prep_in.side.in_bounds = !tx[17] && !ty[17] && (tx < w_eff) && (ty < h_eff);
      prep_in.side.dst_x  = tx[11:0];
      prep_in.side.dst_y  = ty[11:0];
      prep_in.side.copy   = (sa >= aob_pkg::OpaqueLevel) && (da >= aob_pkg::OpaqueLevel);
      for (int k = 0; k < 4; k++) begin
         prep_in.side.mask[k] = (3'(k) < dc);
         prep_in.side.cpy[k]  = (3'(k) < dc) ? ((sc >= dc) ? s[k] : s[0]) : 8'd0;
      end
      prep_in.sa   = sa;
      prep_in.da   = da;
      prep_in.s    = {s[2], s[1], s[0]};
      prep_in.d    = {req_dst_c2, req_dst_c1, req_dst_c0};
   end

   // Stage 2: channel times alpha products and the combined alpha.
   always_comb begin
      logic [7:0] inv;
      inv = aob_pkg::FullAlpha - prep_ff.sa;
      prod_in.side   = prep_ff.side;
      prod_in.inv    = inv;
      prod_in.comb_a = ({prep_ff.sa, 8'd0} - {8'd0, prep_ff.sa}) + 16'(prep_ff.da * inv);
      for (int k = 0; k < 3; k++) begin
         prod_in.p[k] = 16'(prep_ff.s[k] * prep_ff.sa);
         prod_in.q[k] = 16'(prep_ff.d[k] * prep_ff.da);
      end
   end

   // Stage 3: numerators, output alpha (combined alpha / 255) and the blend flag.
   always_comb begin
      logic [16:0] a_sum;
      a_sum = {1'b0, prod_ff.comb_a} + 17'd1 + {9'd0, prod_ff.comb_a[15:8]};
      div_in[0].side        = prod_ff.side;
      div_in[0].side.blend  = (prod_ff.comb_a > aob_pkg::AlphaFloor);
      div_in[0].side.alpha  = a_sum[15:8];
      div_in[0].comb_a      = prod_ff.comb_a;
      div_in[0].quo         = '0;
      for (int k = 0; k < 3; k++) begin
         div_in[0].rem[k] = ({prod_ff.p[k], 8'd0} - {8'd0, prod_ff.p[k]})
                            + 24'(prod_ff.q[k] * prod_ff.inv);
      end
   end

   // Stages 4 to 6: two quotient bits each, most significant first.
   for (genvar i = 1; i <= DivLevels; i++) begin : g_div
      always_comb begin
         div_in[i] = aob_pkg::div_steps(div_ff[i-1],
                        32'(7 - (i - 1) * aob_pkg::DivBitsPerStage));
      end
   end

   // Stage 7: last two quotient bits and the choice between copy, blend and zero.
   always_comb begin
      aob_pkg::div_type fin;
      fin = aob_pkg::div_steps(div_ff[DivLevels],
               32'(7 - DivLevels * aob_pkg::DivBitsPerStage));
      out_in = '0;
      if (fin.side.in_bounds) begin
         out_in.write_enable = 1'b1;
         out_in.dst_x        = fin.side.dst_x;
         out_in.dst_y        = fin.side.dst_y;
         if (fin.side.copy) begin
            out_in.chan = fin.side.cpy;
         end else if (fin.side.blend) begin
            for (int k = 0; k < 3; k++) begin
               out_in.chan[k] = fin.side.mask[k] ? fin.quo[k] : 8'd0;
            end
            out_in.chan[3] = fin.side.mask[3] ? fin.side.alpha : 8'd0;
         end
      end
   end

   // Payload registers load with their stage and need no reset.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         prep_ff <= prep_in;
      end
      if (en[1]) begin
         prod_ff <= prod_in;
      end
      for (int i = 0; i <= DivLevels; i++) begin
         if (en[i+2]) begin
            div_ff[i] <= div_in[i];
         end
      end
      if (en[Stages-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_write_enable = out_ff.write_enable;
   assign rsp_dst_x        = out_ff.dst_x;
   assign rsp_dst_y        = out_ff.dst_y;
   assign rsp_out_c0       = out_ff.chan[0];
   assign rsp_out_c1       = out_ff.chan[1];
   assign rsp_out_c2       = out_ff.chan[2];
   assign rsp_out_c3       = out_ff.chan[3];

endmodule

`default_nettype wire

@@ test/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxDim       = 4096;
   localparam int LatencyWait  = 12;
   localparam int DrainWait    = 20;
   localparam int HoldCycles   = 400;
   localparam int CycleLimit   = 200000;
   localparam int RandomPhases = 12;
   localparam int PhaseItems   = 112;
   localparam int ReportLimit  = 10;

   // One source/destination pixel pair as offered on the req_ channel.
   typedef struct packed {
      logic [11:0]     x;
      logic [11:0]     y;
      logic [3:0][7:0] s;
      logic [3:0][7:0] d;
   } pix_type;

   typedef enum int {
      ReadyAlways,
      ReadyCoin,
      ReadySparse,
      ReadyPeriodic
   } ready_mode_type;

   logic        clock;
   logic        reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_src_x = '0;
   logic [11:0] req_src_y = '0;
   logic [7:0]  req_src_c0 = '0;
   logic [7:0]  req_src_c1 = '0;
   logic [7:0]  req_src_c2 = '0;
   logic [7:0]  req_src_c3 = '0;
   logic [7:0]  req_dst_c0 = '0;
   logic [7:0]  req_dst_c1 = '0;
   logic [7:0]  req_dst_c2 = '0;
   logic [7:0]  req_dst_c3 = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_write_enable;
   logic [11:0] rsp_dst_x;
   logic [11:0] rsp_dst_y;
   logic [7:0]  rsp_out_c0;
   logic [7:0]  rsp_out_c1;
   logic [7:0]  rsp_out_c2;
   logic [7:0]  rsp_out_c3;

   // Mirror of the configuration registers.
   logic [2:0]  cfg_src_ch = 3'd4;
   logic [2:0]  cfg_dst_ch = 3'd4;
   logic [15:0] cfg_off_x = '0;
   logic [15:0] cfg_off_y = '0;
   logic [12:0] cfg_width = 13'd4096;
   logic [12:0] cfg_height = 13'd4096;

   pix_type          pixels_to_send[$];
   aob_pkg::out_type blends_due[$];
   pix_type          cur_pix;
   aob_pkg::out_type seen_result;
   aob_pkg::out_type want_result;

   int      mismatches = 0;
   int      cycle_count = 0;
   int      burst_left = 1;
   int      gap_left = 0;
   int      hold_left = 0;
   int      pat_left = 0;
   int      pat_tick = 0;
   ready_mode_type pat_mode = ReadyAlways;
   bit      stall_request = 1'b0;

   alpha_over_blend #(
      .MAX_DIM(MaxDim)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_src_x       (req_src_x),
      .req_src_y       (req_src_y),
      .req_src_c0      (req_src_c0),
      .req_src_c1      (req_src_c1),
      .req_src_c2      (req_src_c2),
      .req_src_c3      (req_src_c3),
      .req_dst_c0      (req_dst_c0),
      .req_dst_c1      (req_dst_c1),
      .req_dst_c2      (req_dst_c2),
      .req_dst_c3      (req_dst_c3),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_write_enable(rsp_write_enable),
      .rsp_dst_x       (rsp_dst_x),
      .rsp_dst_y       (rsp_dst_y),
      .rsp_out_c0      (rsp_out_c0),
      .rsp_out_c1      (rsp_out_c1),
      .rsp_out_c2      (rsp_out_c2),
      .rsp_out_c3      (rsp_out_c3)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Channel counts of 0 behave as 1 and counts above 4 behave as 4.
   function automatic int effective_channels(input logic [2:0] v);
      int n;
      n = int'(v);
      if (n < 1) n = 1;
      if (n > int'(aob_pkg::MaxChannels)) n = int'(aob_pkg::MaxChannels);
      return n;
   endfunction

   function automatic int dim_limit(input logic [12:0] v);
      return (int'(v) > MaxDim) ? MaxDim : int'(v);
   endfunction

   // Expected output pixel for one input pair under the current configuration.
   function automatic aob_pkg::out_type blend_pixel(input pix_type p);
      aob_pkg::out_type r;
      int      sc, dc, tx, ty, sa, da, comb, num, quo;
      int      s[4];
      int      d[4];
      r = '0;
      sc = effective_channels(cfg_src_ch);
      dc = effective_channels(cfg_dst_ch);
      tx = int'(p.x) + int'($signed(cfg_off_x));
      ty = int'(p.y) + int'($signed(cfg_off_y));
      if (tx < 0 || ty < 0 || tx >= dim_limit(cfg_width) || ty >= dim_limit(cfg_height)) begin
         return r;
      end
      for (int k = 0; k < 4; k++) begin
         s[k] = int'(p.s[k]);
         d[k] = int'(p.d[k]);
      end
      // Channels the source lacks repeat its first channel.
      for (int k = 1; k < 4; k++) begin
         if (k >= sc) s[k] = s[0];
      end
      sa = (sc < 4) ? int'(aob_pkg::FullAlpha) : s[3];
      da = (dc < 4) ? int'(aob_pkg::FullAlpha) : d[3];
      if (sa >= int'(aob_pkg::OpaqueLevel) && da >= int'(aob_pkg::OpaqueLevel)) begin
         for (int k = 0; k < dc; k++) begin
            r.chan[k] = 8'((sc >= dc) ? s[k] : s[0]);
         end
      end else begin
         comb = sa * 255 + da * (255 - sa);
         if (comb > int'(aob_pkg::AlphaFloor)) begin
            for (int k = 0; k < dc; k++) begin
               num = s[k] * sa * 255 + d[k] * da * (255 - sa);
               quo = num / comb;
               r.chan[k] = 8'((quo > 255) ? 255 : quo);
            end
            if (dc > 3) begin
               quo = comb / 255;
               r.chan[3] = 8'((quo > 255) ? 255 : quo);
            end
         end
      end
      r.write_enable = 1'b1;
      r.dst_x = tx[11:0];
      r.dst_y = ty[11:0];
      return r;
   endfunction

   // Bytes lean toward the ends of the range, where the alpha thresholds sit.
   function automatic logic [7:0] pick_byte();
      logic [7:0] v;
      case ($urandom_range(0, 7))
         0: v = 8'd0;
         1: v = 8'd255;
         2: v = 8'($urandom_range(0, 3));
         3: v = 8'($urandom_range(250, 255));
         default: v = 8'($urandom_range(0, 255));
      endcase
      return v;
   endfunction

   // Source coordinate whose target lands in or just around the destination.
   function automatic logic [11:0] pick_coord(input int lim, input logic [15:0] off);
      int t;
      if ($urandom_range(0, 9) == 0) return 12'($urandom_range(0, 4095));
      t = int'($urandom_range(0, lim + 7)) - 4 - int'($signed(off));
      if (t < 0 || t > 4095) return 12'($urandom_range(0, 4095));
      return t[11:0];
   endfunction

   function automatic pix_type random_pixel();
      pix_type p;
      p.x = pick_coord(dim_limit(cfg_width), cfg_off_x);
      p.y = pick_coord(dim_limit(cfg_height), cfg_off_y);
      for (int k = 0; k < 4; k++) begin
         p.s[k] = pick_byte();
         p.d[k] = pick_byte();
      end
      return p;
   endfunction

   function automatic void add_pixel(input logic [11:0] x, input logic [11:0] y,
                                     input logic [31:0] s, input logic [31:0] d);
      pix_type p;
      p.x = x;
      p.y = y;
      p.s = s;
      p.d = d;
      pixels_to_send.push_back(p);
   endfunction

   // One register write; the mirror follows once the transfer completes.
   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         aob_pkg::RegSrcChannels: cfg_src_ch = value[2:0];
         aob_pkg::RegDstChannels: cfg_dst_ch = value[2:0];
         aob_pkg::RegOffsetX:     cfg_off_x = value;
         aob_pkg::RegOffsetY:     cfg_off_y = value;
         aob_pkg::RegDstWidth:    cfg_width = value[12:0];
         aob_pkg::RegDstHeight:   cfg_height = value[12:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int src, input int dst, input int ox, input int oy,
                             input int w, input int h);
      write_reg(aob_pkg::RegSrcChannels, 16'(src));
      write_reg(aob_pkg::RegDstChannels, 16'(dst));
      write_reg(aob_pkg::RegOffsetX, 16'(ox));
      write_reg(aob_pkg::RegOffsetY, 16'(oy));
      write_reg(aob_pkg::RegDstWidth, 16'(w));
      write_reg(aob_pkg::RegDstHeight, 16'(h));
   endtask

   // Waits until nothing is queued, offered or outstanding for a number of cycles.
   task automatic wait_drained(input int settle);
      int quiet;
      quiet = 0;
      while (quiet < settle) begin
         @(posedge clock);
         if (pixels_to_send.size() == 0 && !req_valid && blends_due.size() == 0) begin
            quiet++;
         end else begin
            quiet = 0;
         end
      end
   endtask

   // Stimulus sequence: directed corner cases, then random configurations.
   initial begin
      int w, h, ox, oy;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Default geometry: alpha thresholds and coordinate extremes.
      set_config(4, 4, 0, 0, 4096, 4096);
      add_pixel(0, 0, 32'h00000000, 32'h00000000);
      add_pixel(4095, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
      add_pixel(10, 20, 32'hFD010203, 32'hFD040506);
      add_pixel(11, 21, 32'hFC804020, 32'hFF10E0F0);
      add_pixel(12, 22, 32'hFF804020, 32'hFC10E0F0);
      add_pixel(13, 23, 32'h00C8C8C8, 32'h02646464);
      add_pixel(14, 24, 32'h00C8C8C8, 32'h03646464);
      add_pixel(15, 25, 32'h01FFFFFF, 32'h01FFFFFF);
      add_pixel(16, 26, 32'h80FF0055, 32'h8033CC00);
      wait_drained(LatencyWait);

      // Fewer source channels than destination channels.
      set_config(1, 3, 0, 0, 4096, 4096);
      add_pixel(100, 200, 32'h11223344, 32'h55667788);
      add_pixel(101, 201, 32'h00000000, 32'hFFFFFFFF);
      wait_drained(LatencyWait);
      set_config(3, 4, 0, 0, 4096, 4096);
      add_pixel(300, 400, 32'h10203040, 32'h00506070);
      add_pixel(301, 401, 32'h10203040, 32'hFF506070);
      wait_drained(LatencyWait);

      // Out-of-range channel counts.
      set_config(0, 7, 0, 0, 4096, 4096);
      add_pixel(7, 9, 32'hA0B0C0D0, 32'h20304050);
      wait_drained(LatencyWait);

      // One-pixel destination.
      set_config(4, 4, 0, 0, 1, 1);
      add_pixel(0, 0, 32'h80123456, 32'h80654321);
      add_pixel(1, 0, 32'h80123456, 32'h80654321);
      add_pixel(0, 1, 32'h80123456, 32'h80654321);
      wait_drained(LatencyWait);

      // Offset and size extremes.
      set_config(4, 4, 32767, -32768, 8191, 8191);
      add_pixel(0, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
      wait_drained(LatencyWait);
      set_config(4, 4, -32768, 32767, 8191, 8191);
      add_pixel(4095, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
      wait_drained(LatencyWait);
      set_config(4, 4, 0, 0, 8191, 0);
      add_pixel(4095, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
      wait_drained(LatencyWait);
      set_config(4, 4, -5, 3, 8191, 8191);
      add_pixel(5, 0, 32'h40FFFFFF, 32'hC0000000);
      add_pixel(4, 0, 32'h40FFFFFF, 32'hC0000000);
      add_pixel(4095, 4092, 32'h40FFFFFF, 32'hC0000000);
      wait_drained(LatencyWait);

      // Random configurations, each followed by a random pixel stream.
      for (int ph = 0; ph < RandomPhases; ph++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: w = $urandom_range(1, 64);
            6, 7: w = $urandom_range(4090, 8191);
            default: w = $urandom_range(0, 8191);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: h = $urandom_range(1, 64);
            6, 7: h = $urandom_range(4090, 8191);
            default: h = $urandom_range(0, 8191);
         endcase
         ox = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
                                          : int'($urandom_range(0, 256)) - 128;
         oy = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
                                          : int'($urandom_range(0, 256)) - 128;
         set_config($urandom_range(0, 7), $urandom_range(0, 7), ox, oy, w, h);
         for (int n = 0; n < PhaseItems; n++) begin
            pixels_to_send.push_back(random_pixel());
         end
         // Hold the result side off long enough to back up the pipeline.
         if (ph == 2 || ph == 8) stall_request = 1'b1;
         wait_drained(LatencyWait);
      end

      wait_drained(DrainWait);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Driver: offers queued pixels in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            blends_due.push_back(blend_pixel(cur_pix));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || pixels_to_send.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               cur_pix = pixels_to_send.pop_front();
               req_src_x <= cur_pix.x;
               req_src_y <= cur_pix.y;
               req_src_c0 <= cur_pix.s[0];
               req_src_c1 <= cur_pix.s[1];
               req_src_c2 <= cur_pix.s[2];
               req_src_c3 <= cur_pix.s[3];
               req_dst_c0 <= cur_pix.d[0];
               req_dst_c1 <= cur_pix.d[1];
               req_dst_c2 <= cur_pix.d[2];
               req_dst_c3 <= cur_pix.d[3];
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 30);
                  gap_left = $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Result side: a long hold-off on request, otherwise a changing ready pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_request) begin
         stall_request = 1'b0;
         hold_left = HoldCycles;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            pat_mode = ready_mode_type'($urandom_range(0, 3));
            pat_left = $urandom_range(10, 150);
         end else begin
            pat_left--;
         end
         pat_tick++;
         case (pat_mode)
            ReadyAlways:   rsp_ready <= 1'b1;
            ReadyCoin:     rsp_ready <= 1'($urandom_range(0, 1));
            ReadySparse:   rsp_ready <= ($urandom_range(0, 3) == 0);
            default:       rsp_ready <= ((pat_tick % 8) < 3);
         endcase
      end
   end

   // Monitor: every result transfer is checked against the oldest expected pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_result.write_enable = rsp_write_enable;
         seen_result.dst_x = rsp_dst_x;
         seen_result.dst_y = rsp_dst_y;
         seen_result.chan = {rsp_out_c3, rsp_out_c2, rsp_out_c1, rsp_out_c0};
         if (blends_due.size() == 0) begin
            if (mismatches < ReportLimit) begin
               $display("%0t: result with nothing expected: we=%b x=%0d y=%0d c=%h",
                        $realtime, seen_result.write_enable, seen_result.dst_x,
                        seen_result.dst_y, seen_result.chan);
            end
            mismatches++;
         end else begin
            want_result = blends_due.pop_front();
            if (seen_result !== want_result) begin
               if (mismatches < ReportLimit) begin
                  $display("%0t: mismatch: expected we=%b x=%0d y=%0d c3..c0=%h",
                           $realtime, want_result.write_enable, want_result.dst_x,
                           want_result.dst_y, want_result.chan);
                  $display("%0t:           actual   we=%b x=%0d y=%0d c3..c0=%h",
                           $realtime, seen_result.write_enable, seen_result.dst_x,
                           seen_result.dst_y, seen_result.chan);
               end
               mismatches++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
